// File: hdl/malm_pkg.sv
`timescale 1ns / 1ps

package malm_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int RANK_W = IDX_W;
	localparam int LEN_W = IDX_W + 1;
	localparam int ADDR_BITS = 10;
	localparam int TYPE_W = 2;
	localparam int CL_W = 6;
	localparam int PORT_W = 5;
	localparam int RAW_W = 11;
	localparam int KEY_W = 15;
	localparam int MASK_W = 16;
	localparam int CNT_W = 8;
	localparam int ST_W = 4;
	localparam int SLOT_W = 4;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOCK       = 2'd0,
		REQ_UNLOCK     = 2'd1,
		REQ_UNLOCK_ALL = 2'd2,
		REQ_RESERVED   = 2'd3
	} req_kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_NEW      = 4'd0,
		ST_RAISED   = 4'd1,
		ST_QUEUED   = 4'd2,
		ST_FULL     = 4'd3,
		ST_LOWERED  = 4'd4,
		ST_REMOVED  = 4'd5,
		ST_NOTFOUND = 4'd6,
		ST_WAKE     = 4'd7,
		ST_SAT      = 4'd8
	} lock_status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_NEXT,
		OP_RSTR,
		OP_SAT,
		OP_RAISE,
		OP_NEWG,
		OP_NEWW,
		OP_FULL,
		OP_NOTF,
		OP_LOWER,
		OP_RELEASE,
		OP_DROP,
		OP_WAKE,
		OP_FLUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   grant_list;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic ovl_req;
		logic same_cl;
		logic mask_eq;
		logic cnt_max;
		logic cnt_ge2;
		logic cnt_eq1;
		logic ovl_rel;
		logic blocked;
		logic free_any;
		logic pend_v;
		logic out_free;
	} sts_t;

	function automatic logic overlaps(input logic [KEY_W-1:0] ka, input logic [MASK_W-1:0] ma,
		input logic [KEY_W-1:0] kb, input logic [MASK_W-1:0] mb);
		logic [MASK_W-1:0] diff;
		diff = MASK_W'(ka ^ kb) & ~(ma | mb);
		return diff == '0;
	endfunction

endpackage

// File: hdl/malm_req_if.sv
`timescale 1ns / 1ps

interface malm_req_if;
	logic                        valid;
	logic                        ready;
	logic [malm_pkg::TYPE_W-1:0] req_type;
	logic [malm_pkg::CL_W-1:0]   requester;
	logic [malm_pkg::PORT_W-1:0] port;
	logic [malm_pkg::RAW_W-1:0]  raw_addr;
	logic [malm_pkg::MASK_W-1:0] range_mask;

	modport source(output valid, req_type, requester, port, raw_addr, range_mask, input ready);
	modport sink(input valid, req_type, requester, port, raw_addr, range_mask, output ready);
endinterface

// File: hdl/malm_rsp_if.sv
`timescale 1ns / 1ps

interface malm_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [malm_pkg::ST_W-1:0]   status;
	logic [malm_pkg::SLOT_W-1:0] entry_slot;
	logic [malm_pkg::CL_W-1:0]   owner_client;
	logic [malm_pkg::KEY_W-1:0]  lock_key;
	logic [malm_pkg::MASK_W-1:0] lock_mask;
	logic                        last;

	modport source(output valid, status, entry_slot, owner_client, lock_key, lock_mask, last,
		input ready);
	modport sink(input valid, status, entry_slot, owner_client, lock_key, lock_mask, last,
		output ready);
endinterface

// File: hdl/masked_address_lock_manager.sv
`timescale 1ns / 1ps

// Masked address lock manager: a 16-slot table of lock ranges kept on a granted list
// and a wait queue. One request is worked at a time; the controller visits one list
// rank per cycle while the result channel can take a result; in an unlock-all, each
// release rescans the wait queue and the granted scan restarts after it.
// Every lock, unlock or unlock-all request yields one or more results and the last one
// carries last = 1; a request of the reserved type yields none.
module masked_address_lock_manager (
	input logic        clk,
	input logic        arst_n,
	malm_req_if.sink   req,
	malm_rsp_if.source rsp
);
	import malm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	malm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.req_type (req.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	malm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.requester    (req.requester),
		.port         (req.port),
		.raw_addr     (req.raw_addr),
		.range_mask   (req.range_mask),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.status       (rsp.status),
		.entry_slot   (rsp.entry_slot),
		.owner_client (rsp.owner_client),
		.lock_key     (rsp.lock_key),
		.lock_mask    (rsp.lock_mask),
		.last         (rsp.last)
	);

endmodule

// File: hdl/malm_dp.sv
`timescale 1ns / 1ps

module malm_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  malm_pkg::cmd_t              cmd,
	output malm_pkg::sts_t              sts,
	input  logic [malm_pkg::CL_W-1:0]   requester,
	input  logic [malm_pkg::PORT_W-1:0] port,
	input  logic [malm_pkg::RAW_W-1:0]  raw_addr,
	input  logic [malm_pkg::MASK_W-1:0] range_mask,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [malm_pkg::ST_W-1:0]   status,
	output logic [malm_pkg::SLOT_W-1:0] entry_slot,
	output logic [malm_pkg::CL_W-1:0]   owner_client,
	output logic [malm_pkg::KEY_W-1:0]  lock_key,
	output logic [malm_pkg::MASK_W-1:0] lock_mask,
	output logic                        last
);
	import malm_pkg::*;

	logic [TABLE_ENTRIES-1:0] valid_q, granted_q;
	logic [CL_W-1:0]   client_q [TABLE_ENTRIES];
	logic [KEY_W-1:0]  key_q    [TABLE_ENTRIES];
	logic [MASK_W-1:0] mask_q   [TABLE_ENTRIES];
	logic [CNT_W-1:0]  count_q  [TABLE_ENTRIES];
	logic [RANK_W-1:0] rank_q   [TABLE_ENTRIES];
	logic [LEN_W-1:0]  len_g_q, len_w_q, r_q;

	logic [CL_W-1:0]   req_cl_q;
	logic [KEY_W-1:0]  req_key_q, rel_key_q;
	logic [MASK_W-1:0] req_mask_q, rel_mask_q;

	logic              pend_v_q;
	lock_status_t      pend_st_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [CL_W-1:0]   pend_cl_q;
	logic [KEY_W-1:0]  pend_key_q;
	logic [MASK_W-1:0] pend_mask_q;

	logic              out_v_q, out_last_q;
	lock_status_t      out_st_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [CL_W-1:0]   out_cl_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [MASK_W-1:0] out_mask_q;

	logic [TABLE_ENTRIES-1:0] sel;
	logic [IDX_W-1:0]  cur, free_idx;
	logic              found, blocked, out_free;
	logic [CL_W-1:0]   cur_cl;
	logic [KEY_W-1:0]  cur_key, in_key;
	logic [MASK_W-1:0] cur_mask;
	logic [CNT_W-1:0]  cur_cnt;
	logic              g;

	logic              emit_en;
	lock_status_t      e_st;
	logic [IDX_W-1:0]  e_slot;
	logic [CL_W-1:0]   e_cl;
	logic [KEY_W-1:0]  e_key;
	logic [MASK_W-1:0] e_mask;

	assign g = cmd.grant_list;
	assign in_key = KEY_W'((32'(port) << ADDR_BITS) | (32'(raw_addr) >> 1));

	// entry at rank r_q of the selected list
	always_comb begin
		cur = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			sel[i] = valid_q[i] && (granted_q[i] == g) && (r_q < LEN_W'(TABLE_ENTRIES)) &&
				(rank_q[i] == r_q[RANK_W-1:0]);
			if (sel[i]) cur = IDX_W'(i);
		end
		found = |sel;
	end

	always_comb begin
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
	end

	assign cur_cl = client_q[cur];
	assign cur_key = key_q[cur];
	assign cur_mask = mask_q[cur];
	assign cur_cnt = count_q[cur];

	// a waiter is blocked by any granted range of another client
	always_comb begin
		blocked = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (valid_q[i] && granted_q[i] && client_q[i] != cur_cl &&
				overlaps(cur_key, cur_mask, key_q[i], mask_q[i]))
				blocked = 1'b1;
		end
	end

	assign out_free = !out_v_q || out_ready;

	always_comb begin
		sts.found    = found;
		sts.ovl_req  = overlaps(cur_key, cur_mask, req_key_q, req_mask_q);
		sts.same_cl  = cur_cl == req_cl_q;
		sts.mask_eq  = cur_mask == req_mask_q;
		sts.cnt_max  = cur_cnt == COUNT_MAX;
		sts.cnt_ge2  = cur_cnt >= CNT_W'(2);
		sts.cnt_eq1  = cur_cnt == CNT_W'(1);
		sts.ovl_rel  = overlaps(cur_key, cur_mask, rel_key_q, rel_mask_q);
		sts.blocked  = blocked;
		sts.free_any = ~&valid_q;
		sts.pend_v   = pend_v_q;
		sts.out_free = out_free;
	end

	always_comb begin
		emit_en = 1'b1;
		e_st = ST_REMOVED;
		e_slot = cur;
		e_cl = cur_cl;
		e_key = cur_key;
		e_mask = cur_mask;
		case (cmd.op)
			OP_SAT:     e_st = ST_SAT;
			OP_RAISE:   e_st = ST_RAISED;
			OP_LOWER:   e_st = ST_LOWERED;
			OP_RELEASE: e_st = ST_REMOVED;
			OP_DROP:    e_st = ST_REMOVED;
			OP_WAKE:    e_st = ST_WAKE;
			OP_NEWG, OP_NEWW: begin
				e_st = (cmd.op == OP_NEWG) ? ST_NEW : ST_QUEUED;
				e_slot = free_idx;
				e_cl = req_cl_q;
				e_key = req_key_q;
				e_mask = req_mask_q;
			end
			OP_FULL, OP_NOTF: begin
				e_st = (cmd.op == OP_FULL) ? ST_FULL : ST_NOTFOUND;
				e_slot = '0;
				e_cl = req_cl_q;
				e_key = req_key_q;
				e_mask = req_mask_q;
			end
			default:    emit_en = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			granted_q <= '0;
			len_g_q <= '0;
			len_w_q <= '0;
			r_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD, OP_RSTR, OP_RELEASE: r_q <= '0;
				OP_NEXT:                      r_q <= r_q + 1'b1;
				default:                      ;
			endcase
			case (cmd.op)
				OP_NEWG: begin
					valid_q[free_idx] <= 1'b1;
					granted_q[free_idx] <= 1'b1;
					len_g_q <= len_g_q + 1'b1;
				end
				OP_NEWW: begin
					valid_q[free_idx] <= 1'b1;
					granted_q[free_idx] <= 1'b0;
					len_w_q <= len_w_q + 1'b1;
				end
				OP_RELEASE, OP_DROP: begin
					valid_q[cur] <= 1'b0;
					granted_q[cur] <= 1'b0;
					if (g) len_g_q <= len_g_q - 1'b1;
					else len_w_q <= len_w_q - 1'b1;
				end
				OP_WAKE: begin
					granted_q[cur] <= 1'b1;
					len_g_q <= len_g_q + 1'b1;
					len_w_q <= len_w_q - 1'b1;
				end
				default: ;
			endcase
			if (emit_en) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) out_v_q <= 1'b1;
				else if (out_ready) out_v_q <= 1'b0;
			end else if (cmd.op == OP_FLUSH) begin
				pend_v_q <= 1'b0;
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// table and result payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			req_cl_q <= requester;
			req_key_q <= in_key;
			req_mask_q <= range_mask;
		end
		if (cmd.op == OP_RELEASE) begin
			rel_key_q <= cur_key;
			rel_mask_q <= cur_mask;
		end
		if (cmd.op == OP_RELEASE || cmd.op == OP_DROP || cmd.op == OP_WAKE) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (IDX_W'(i) != cur && valid_q[i] && granted_q[i] == g &&
					rank_q[i] > r_q[RANK_W-1:0])
					rank_q[i] <= rank_q[i] - 1'b1;
			end
		end
		case (cmd.op)
			OP_NEWG, OP_NEWW: begin
				client_q[free_idx] <= req_cl_q;
				key_q[free_idx] <= req_key_q;
				mask_q[free_idx] <= req_mask_q;
				count_q[free_idx] <= (cmd.op == OP_NEWG) ? CNT_W'(1) : '0;
				rank_q[free_idx] <= (cmd.op == OP_NEWG) ? len_g_q[RANK_W-1:0] :
					len_w_q[RANK_W-1:0];
			end
			OP_RAISE: count_q[cur] <= cur_cnt + 1'b1;
			OP_LOWER: count_q[cur] <= cur_cnt - 1'b1;
			OP_WAKE: begin
				count_q[cur] <= CNT_W'(1);
				rank_q[cur] <= len_g_q[RANK_W-1:0];
			end
			default: ;
		endcase
		if (emit_en) begin
			pend_st_q <= e_st;
			pend_slot_q <= SLOT_W'(e_slot);
			pend_cl_q <= e_cl;
			pend_key_q <= e_key;
			pend_mask_q <= e_mask;
		end
		if ((emit_en && pend_v_q) || cmd.op == OP_FLUSH) begin
			out_st_q <= pend_st_q;
			out_slot_q <= pend_slot_q;
			out_cl_q <= pend_cl_q;
			out_key_q <= pend_key_q;
			out_mask_q <= pend_mask_q;
			out_last_q <= cmd.op == OP_FLUSH;
		end
	end

	assign out_valid = out_v_q;
	assign status = out_st_q;
	assign entry_slot = out_slot_q;
	assign owner_client = out_cl_q;
	assign lock_key = out_key_q;
	assign lock_mask = out_mask_q;
	assign last = out_last_q;

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == (32'(len_g_q) + 32'(len_w_q)))
		else $error("valid entries disagree with list lengths");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> out_free)
		else $error("result produced while output register is held");

	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FLUSH |-> pend_v_q && out_free)
		else $error("flush without a pending result");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_NEWG || cmd.op == OP_NEWW) |-> !valid_q[free_idx])
		else $error("new entry written over a live slot");

endmodule

// File: hdl/malm_ctrl.sv
`timescale 1ns / 1ps

module malm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [malm_pkg::TYPE_W-1:0] req_type,
	input  malm_pkg::sts_t              sts,
	output malm_pkg::cmd_t              cmd
);
	import malm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_LOCK, S_FIND_G, S_FIND_W, S_WAKE, S_UA_DROP, S_UA_REL, S_FINISH
	} state_t;

	state_t state_q, nxt;
	logic   ua_q;
	logic   exact_cl;

	assign exact_cl = sts.same_cl && sts.mask_eq && sts.ovl_req;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd.op = OP_NONE;
		cmd.grant_list = 1'b0;
		nxt = state_q;
		if (state_q == S_IDLE) begin
			if (in_valid) begin
				cmd.op = OP_LOAD;
				case (req_type)
					REQ_LOCK:       nxt = S_LOCK;
					REQ_UNLOCK:     nxt = S_FIND_G;
					REQ_UNLOCK_ALL: nxt = S_UA_DROP;
					default:        nxt = S_FINISH;
				endcase
			end
		end else if (sts.out_free) begin
			case (state_q)
				S_LOCK: begin
					cmd.grant_list = 1'b1;
					nxt = S_FINISH;
					if (sts.found && sts.ovl_req) begin
						if (sts.same_cl && sts.mask_eq)
							cmd.op = sts.cnt_max ? OP_SAT : OP_RAISE;
						else if (!sts.free_any)
							cmd.op = OP_FULL;
						else
							cmd.op = sts.same_cl ? OP_NEWG : OP_NEWW;
					end else if (sts.found) begin
						cmd.op = OP_NEXT;
						nxt = S_LOCK;
					end else begin
						cmd.op = sts.free_any ? OP_NEWG : OP_FULL;
					end
				end
				S_FIND_G, S_FIND_W: begin
					cmd.grant_list = state_q == S_FIND_G;
					if (sts.found && exact_cl) begin
						if (sts.cnt_ge2) begin
							cmd.op = OP_LOWER;
							nxt = S_FINISH;
						end else if (sts.cnt_eq1) begin
							cmd.op = OP_RELEASE;
							nxt = S_WAKE;
						end else begin
							cmd.op = OP_DROP;
							nxt = S_FINISH;
						end
					end else if (sts.found) begin
						cmd.op = OP_NEXT;
					end else if (state_q == S_FIND_G) begin
						cmd.op = OP_RSTR;
						nxt = S_FIND_W;
					end else begin
						cmd.op = OP_NOTF;
						nxt = S_FINISH;
					end
				end
				S_WAKE: begin
					if (sts.found) begin
						cmd.op = (sts.ovl_rel && !sts.blocked) ? OP_WAKE : OP_NEXT;
					end else if (ua_q) begin
						cmd.op = OP_RSTR;
						nxt = S_UA_REL;
					end else begin
						nxt = S_FINISH;
					end
				end
				S_UA_DROP: begin
					if (sts.found) begin
						cmd.op = sts.same_cl ? OP_DROP : OP_NEXT;
					end else begin
						cmd.op = OP_RSTR;
						nxt = S_UA_REL;
					end
				end
				S_UA_REL: begin
					cmd.grant_list = 1'b1;
					if (sts.found && sts.same_cl) begin
						cmd.op = OP_RELEASE;
						nxt = S_WAKE;
					end else if (sts.found) begin
						cmd.op = OP_NEXT;
					end else begin
						// client held nothing at all
						if (!sts.pend_v) cmd.op = OP_NOTF;
						nxt = S_FINISH;
					end
				end
				S_FINISH: begin
					if (sts.pend_v) cmd.op = OP_FLUSH;
					nxt = S_IDLE;
				end
				default: nxt = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ua_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.op == OP_LOAD) ua_q <= req_type == REQ_UNLOCK_ALL;
		end
	end

endmodule

// File: tb/malm_tb_pkg.sv
`timescale 1ns / 1ps

package malm_tb_pkg;
	import malm_pkg::*;

	typedef struct {
		logic [TYPE_W-1:0] kind;
		logic [CL_W-1:0]   client;
		logic [PORT_W-1:0] port;
		logic [RAW_W-1:0]  raw;
		logic [MASK_W-1:0] mask;
	} lock_req_t;

	typedef struct {
		lock_status_t      status;
		logic [SLOT_W-1:0] slot;
		logic [CL_W-1:0]   client;
		logic [KEY_W-1:0]  key;
		logic [MASK_W-1:0] mask;
		logic              last;
	} lock_rsp_t;
endpackage

// File: tb/masked_address_lock_manager_tb.sv
`timescale 1ns / 1ps

module masked_address_lock_manager_tb;
	import malm_pkg::*;
	import malm_tb_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int N_RANDOM = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   errors = 0;
	bit   feed_done = 1'b0;
	bit   hold_off = 1'b0;
	bit   calm = 1'b0;

	malm_req_if req ();
	malm_rsp_if rsp ();

	masked_address_lock_manager i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the lock table
	bit                s_valid   [TABLE_ENTRIES];
	bit                s_granted [TABLE_ENTRIES];
	logic [CL_W-1:0]   s_client  [TABLE_ENTRIES];
	logic [KEY_W-1:0]  s_key     [TABLE_ENTRIES];
	logic [MASK_W-1:0] s_mask    [TABLE_ENTRIES];
	int                s_count   [TABLE_ENTRIES];
	int                s_rank    [TABLE_ENTRIES];

	lock_rsp_t pending_rsp[$];
	lock_rsp_t step_rsp[$];

	function automatic bit ranges_overlap(logic [KEY_W-1:0] ka, logic [MASK_W-1:0] ma,
		logic [KEY_W-1:0] kb, logic [MASK_W-1:0] mb);
		logic [MASK_W-1:0] d;
		d = {1'b0, ka ^ kb} & ~(ma | mb);
		return d == '0;
	endfunction

	function automatic void note(lock_status_t st, int s, logic [CL_W-1:0] c,
		logic [KEY_W-1:0] k, logic [MASK_W-1:0] m);
		lock_rsp_t r;
		r.status = st;
		r.slot = SLOT_W'(s);
		r.client = c;
		r.key = k;
		r.mask = m;
		r.last = 1'b0;
		step_rsp.push_back(r);
	endfunction

	function automatic void note_slot(lock_status_t st, int s);
		note(st, s, s_client[s], s_key[s], s_mask[s]);
	endfunction

	function automatic int list_len(bit g);
		int n;
		n = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (s_valid[i] && s_granted[i] == g) n++;
		return n;
	endfunction

	function automatic int slot_at(bit g, int r);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (s_valid[i] && s_granted[i] == g && s_rank[i] == r) return i;
		return -1;
	endfunction

	function automatic void unlink(int s);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (i != s && s_valid[i] && s_granted[i] == s_granted[s] && s_rank[i] > s_rank[s])
				s_rank[i]--;
	endfunction

	function automatic void push_tail(int s, bit g);
		s_valid[s] = 1'b0;
		s_rank[s] = list_len(g);
		s_granted[s] = g;
		s_valid[s] = 1'b1;
	endfunction

	function automatic bit held_by_other(int w);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (s_valid[i] && s_granted[i] && s_client[i] != s_client[w] &&
				ranges_overlap(s_key[w], s_mask[w], s_key[i], s_mask[i]))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void remove_slot(int s);
		note_slot(ST_REMOVED, s);
		unlink(s);
		s_valid[s] = 1'b0;
		s_granted[s] = 1'b0;
	endfunction

	function automatic void release_lock(int s);
		logic [KEY_W-1:0]  rk;
		logic [MASK_W-1:0] rm;
		int r, w;
		rk = s_key[s];
		rm = s_mask[s];
		r = 0;
		remove_slot(s);
		w = slot_at(1'b0, r);
		while (w >= 0) begin
			if (ranges_overlap(s_key[w], s_mask[w], rk, rm) && !held_by_other(w)) begin
				unlink(w);
				push_tail(w, 1'b1);
				s_count[w] = 1;
				note_slot(ST_WAKE, w);
			end else begin
				r++;
			end
			w = slot_at(1'b0, r);
		end
	endfunction

	function automatic int find_exact(bit g, logic [CL_W-1:0] c, logic [KEY_W-1:0] k,
		logic [MASK_W-1:0] m);
		int s, n;
		n = list_len(g);
		for (int r = 0; r < n; r++) begin
			s = slot_at(g, r);
			if (s >= 0 && s_client[s] == c && s_mask[s] == m &&
				ranges_overlap(k, m, s_key[s], s_mask[s]))
				return s;
		end
		return -1;
	endfunction

	function automatic void take_lock(logic [CL_W-1:0] c, logic [KEY_W-1:0] k,
		logic [MASK_W-1:0] m);
		int n, s, hit, f;
		hit = -1;
		n = list_len(1'b1);
		for (int r = 0; r < n && hit < 0; r++) begin
			s = slot_at(1'b1, r);
			if (s >= 0 && ranges_overlap(s_key[s], s_mask[s], k, m)) hit = s;
		end
		if (hit >= 0 && s_client[hit] == c && s_mask[hit] == m) begin
			if (s_count[hit] >= 255) begin
				note_slot(ST_SAT, hit);
			end else begin
				s_count[hit]++;
				note_slot(ST_RAISED, hit);
			end
			return;
		end
		f = -1;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
			if (!s_valid[i]) f = i;
		if (f < 0) begin
			note(ST_FULL, 0, c, k, m);
			return;
		end
		s_client[f] = c;
		s_key[f] = k;
		s_mask[f] = m;
		if (hit >= 0 && s_client[hit] != c) begin
			s_count[f] = 0;
			push_tail(f, 1'b0);
			note_slot(ST_QUEUED, f);
		end else begin
			s_count[f] = 1;
			push_tail(f, 1'b1);
			note_slot(ST_NEW, f);
		end
	endfunction

	// works out the responses of one request and updates the shadow table
	function automatic void predict_locks(lock_req_t q);
		logic [KEY_W-1:0] k;
		int s, r, pick;
		step_rsp.delete();
		k = KEY_W'({q.port, 10'b0} | (q.raw >> 1));
		case (q.kind)
			REQ_LOCK: take_lock(q.client, k, q.mask);
			REQ_UNLOCK: begin
				s = find_exact(1'b1, q.client, k, q.mask);
				if (s < 0) s = find_exact(1'b0, q.client, k, q.mask);
				if (s < 0) note(ST_NOTFOUND, 0, q.client, k, q.mask);
				else if (s_count[s] >= 2) begin
					s_count[s]--;
					note_slot(ST_LOWERED, s);
				end else if (s_count[s] == 1) release_lock(s);
				else remove_slot(s);
			end
			REQ_UNLOCK_ALL: begin
				r = 0;
				s = slot_at(1'b0, r);
				while (s >= 0) begin
					if (s_client[s] == q.client) remove_slot(s);
					else r++;
					s = slot_at(1'b0, r);
				end
				pick = 0;
				while (pick >= 0) begin
					pick = -1;
					for (r = 0; r < list_len(1'b1) && pick < 0; r++) begin
						s = slot_at(1'b1, r);
						if (s >= 0 && s_client[s] == q.client) pick = s;
					end
					if (pick >= 0) release_lock(pick);
				end
				if (step_rsp.size() == 0) note(ST_NOTFOUND, 0, q.client, k, q.mask);
			end
			default: ;
		endcase
		if (step_rsp.size() > 0) step_rsp[step_rsp.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// stimulus pool: a small set of clients and ranges so locks collide
	logic [PORT_W-1:0] hot_port [4] = '{5'd0, 5'd31, 5'd3, 5'd17};

	function automatic lock_req_t rand_req();
		lock_req_t q;
		int p;
		p = $urandom_range(0, 99);
		q.kind = (p < 50) ? REQ_LOCK : (p < 88) ? REQ_UNLOCK : (p < 97) ? REQ_UNLOCK_ALL :
			REQ_RESERVED;
		q.client = ($urandom_range(0, 9) == 0) ? CL_W'($urandom) : CL_W'($urandom_range(0, 3));
		if ($urandom_range(0, 5) == 0) begin
			q.port = PORT_W'($urandom);
			q.raw = RAW_W'($urandom);
			q.mask = MASK_W'($urandom);
		end else begin
			q.port = hot_port[$urandom_range(0, 3)];
			q.raw = RAW_W'($urandom_range(0, 7)) | (RAW_W'($urandom_range(0, 1)) << 10);
			case ($urandom_range(0, 3))
				0: q.mask = '0;
				1: q.mask = 16'h0003;
				2: q.mask = 16'h03ff;
				default: q.mask = MASK_W'($urandom_range(0, 7));
			endcase
			if ($urandom_range(0, 15) == 0) q.mask[15:10] = 6'($urandom);
		end
		return q;
	endfunction

	// directed rows; want_st is checked on the first response when check is set
	typedef struct {
		logic [TYPE_W-1:0] kind;
		logic [CL_W-1:0]   client;
		logic [PORT_W-1:0] port;
		logic [RAW_W-1:0]  raw;
		logic [MASK_W-1:0] mask;
		bit                check;
		lock_status_t      want_st;
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		'{REQ_UNLOCK,     6'd0,  5'd0,  11'd0,    16'h0000, 1'b1, ST_NOTFOUND},
		'{REQ_UNLOCK_ALL, 6'd63, 5'd31, 11'd2047, 16'hffff, 1'b1, ST_NOTFOUND},
		'{REQ_LOCK,       6'd1,  5'd0,  11'd0,    16'h0000, 1'b1, ST_NEW},
		'{REQ_LOCK,       6'd1,  5'd0,  11'd1,    16'h0000, 1'b1, ST_RAISED},
		'{REQ_LOCK,       6'd2,  5'd0,  11'd0,    16'h0003, 1'b1, ST_QUEUED},
		'{REQ_LOCK,       6'd1,  5'd0,  11'd0,    16'h0001, 1'b0, ST_NEW},
		'{REQ_LOCK,       6'd63, 5'd31, 11'd2047, 16'h0000, 1'b1, ST_NEW},
		'{REQ_LOCK,       6'd3,  5'd31, 11'd2046, 16'hffff, 1'b1, ST_QUEUED},
		'{REQ_UNLOCK,     6'd1,  5'd0,  11'd0,    16'h0000, 1'b1, ST_LOWERED},
		'{REQ_UNLOCK,     6'd1,  5'd0,  11'd0,    16'h0000, 1'b1, ST_REMOVED},
		'{REQ_UNLOCK,     6'd2,  5'd0,  11'd0,    16'h0003, 1'b0, ST_REMOVED},
		'{REQ_UNLOCK,     6'd3,  5'd31, 11'd2047, 16'hffff, 1'b1, ST_REMOVED},
		'{REQ_RESERVED,   6'd5,  5'd5,  11'd5,    16'h5555, 1'b0, ST_NEW},
		'{REQ_UNLOCK_ALL, 6'd1,  5'd0,  11'd0,    16'h0000, 1'b1, ST_REMOVED},
		'{REQ_UNLOCK_ALL, 6'd63, 5'd0,  11'd0,    16'h0000, 1'b1, ST_REMOVED},
		'{REQ_UNLOCK_ALL, 6'd2,  5'd0,  11'd0,    16'h0000, 1'b0, ST_REMOVED}
	};

	int     first_check[$];
	lock_status_t first_want[$];

	task automatic send_req(lock_req_t q, bit check, lock_status_t want);
		while (!calm && $urandom_range(0, 99) < 19) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		predict_locks(q);
		if (step_rsp.size() > 0) begin
			first_check.push_back(check);
			first_want.push_back(want);
		end
		foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
		req.valid <= 1'b1;
		req.req_type <= q.kind;
		req.requester <= q.client;
		req.port <= q.port;
		req.raw_addr <= q.raw;
		req.range_mask <= q.mask;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic check_rsp();
		lock_rsp_t w;
		if (pending_rsp.size() == 0) begin
			report_mismatch("unexpected response", 32'(rsp.status), 32'd0);
			return;
		end
		w = pending_rsp.pop_front();
		if (rsp.status != w.status)
			report_mismatch("status", 32'(rsp.status), 32'(w.status));
		if (rsp.entry_slot != w.slot)
			report_mismatch("entry_slot", 32'(rsp.entry_slot), 32'(w.slot));
		if (rsp.owner_client != w.client)
			report_mismatch("owner_client", 32'(rsp.owner_client), 32'(w.client));
		if (rsp.lock_key != w.key)
			report_mismatch("lock_key", 32'(rsp.lock_key), 32'(w.key));
		if (rsp.lock_mask != w.mask)
			report_mismatch("lock_mask", 32'(rsp.lock_mask), 32'(w.mask));
		if (rsp.last != w.last)
			report_mismatch("last", 32'(rsp.last), 32'(w.last));
		if (rsp.last && first_check.size() > 0) begin
			void'(first_check.pop_front());
			void'(first_want.pop_front());
		end
	endtask

	// typed-in first statuses are checked on the response that opens each request
	bit opening = 1'b1;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (opening && first_check.size() > 0 && first_check[0] &&
				rsp.status != first_want[0])
				report_mismatch("directed status", 32'(rsp.status), 32'(first_want[0]));
			opening = rsp.last;
			check_rsp();
		end
	end

	initial begin
		int hold;
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp.ready <= 1'b0;
				hold = 0;
				while (hold < 400) begin
					@(posedge clk);
					hold++;
				end
				hold_off = 1'b0;
			end
			rsp.ready <= calm || $urandom_range(0, 99) >= 19;
		end
	end

	initial begin
		lock_req_t q;
		req.valid <= 1'b0;
		req.req_type <= REQ_LOCK;
		req.requester <= '0;
		req.port <= '0;
		req.raw_addr <= '0;
		req.range_mask <= '0;
		foreach (s_valid[i]) begin
			s_valid[i] = 1'b0;
			s_granted[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			q.kind = dir_rows[i].kind;
			q.client = dir_rows[i].client;
			q.port = dir_rows[i].port;
			q.raw = dir_rows[i].raw;
			q.mask = dir_rows[i].mask;
			send_req(q, dir_rows[i].check, dir_rows[i].want_st);
		end
		// fill the table and hit count saturation
		for (int i = 0; i < 17; i++) begin
			q = '{REQ_LOCK, 6'd9, 5'(i), 11'd0, 16'h0000};
			send_req(q, 1'b0, ST_NEW);
		end
		for (int i = 0; i < 256; i++) begin
			q = '{REQ_LOCK, 6'd9, 5'd0, 11'd0, 16'h0000};
			send_req(q, i == 255, ST_SAT);
		end
		q = '{REQ_UNLOCK_ALL, 6'd9, 5'd0, 11'd0, 16'h0000};
		send_req(q, 1'b1, ST_REMOVED);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 40) hold_off = 1'b1;
			calm = (n >= 80 && n < 140);
			send_req(rand_req(), 1'b0, ST_NEW);
		end
		calm = 1'b0;
		req.valid <= 1'b0;
		feed_done = 1'b1;
	end

	initial begin
		wait (feed_done && pending_rsp.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("PASS masked_address_lock_manager");
		end else begin
			$display("FAIL masked_address_lock_manager");
		end
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("FAIL masked_address_lock_manager");
		$finish;
	end
endmodule

// File: filelist.f
hdl/malm_pkg.sv
hdl/malm_req_if.sv
hdl/malm_rsp_if.sv
hdl/malm_dp.sv
hdl/malm_ctrl.sv
hdl/masked_address_lock_manager.sv
tb/malm_tb_pkg.sv
tb/masked_address_lock_manager_tb.sv
